/* rtl/ptw_pkg.sv */
// Package for the four-level page table walker: payload structs, level
// codes, physical address masks and constants. No dependencies.
package ptw_pkg;

    localparam int PHYS_TOP_BIT = 51;
    localparam int VA_W         = 48;
    localparam int RD_ADDR_W    = 52;
    localparam int IDX_W        = 9;

    localparam logic [63:0] PHYS_MASK = 64'((65'd1 << (PHYS_TOP_BIT + 1)) - 65'd1);
    localparam logic [63:0] FRAME_4K_MASK = PHYS_MASK & ~64'h0000_0000_0000_0FFF;
    localparam logic [63:0] FRAME_2M_MASK = PHYS_MASK & ~64'h0000_0000_001F_FFFF;
    localparam logic [63:0] FRAME_1G_MASK = PHYS_MASK & ~64'h0000_0000_3FFF_FFFF;
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ENTRY = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] PAGE_4K      = 2'd0;
    localparam logic [1:0] PAGE_2M      = 2'd1;
    localparam logic [1:0] PAGE_1G      = 2'd2;
    localparam logic [1:0] PAGE_UNPAGED = 2'd3;

    typedef enum logic [2:0] {
        LVL_IDLE = 3'd0,
        LVL_1    = 3'd1,
        LVL_2    = 3'd2,
        LVL_3    = 3'd3,
        LVL_4    = 3'd4
    } t_walk_level;

    typedef struct packed {
        logic        cmd;
        logic [63:0] root_table;
        logic [63:0] virt_addr;
        logic        use_snapshot;
        logic [63:0] entry_data;
        logic        read_failed;
    } t_ptw_in;

    typedef struct packed {
        logic                 kind;
        logic [RD_ADDR_W-1:0] read_addr;
        logic                 rd_snap;
        logic [63:0]          xlat_addr;
        logic                 fault;
        logic [1:0]           page_kind;
    } t_ptw_out;

    typedef struct packed {
        logic        res_valid;
        logic        latch_start;
        t_walk_level level;
        t_ptw_out    res;
    } t_ptw_step;

endpackage

/* rtl/four_level_page_table_walker_top.sv */
// Top level of the four-level page table walker: input register, walk
// state, step logic and result register. Depends on ptw_pkg and ptw_step.
//
//   channel | direction | payload    | handshake
//   in      | input     | t_ptw_in   | i_in_valid / o_in_stall
//   out     | output    | t_ptw_out  | o_out_valid / i_out_stall
//   cfg     | input     | paging bit | i_cfg_we / i_cfg_wdata
//
// One transaction per cycle while the output is not stalled.
// The input register feeds the step logic, which loads the result register.
// Reset clears the walk level, the mode bit and both valid flags.
// A stalled output holds the input register when its item yields a result,
// and stall reaches the input only when that register is full.
module four_level_page_table_walker_top import ptw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ptw_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_ptw_out o_out_data
);

    logic            r_paging_mode;
    t_walk_level     r_level;
    logic [VA_W-1:0] r_saved_va;
    logic            r_saved_snap;
    logic            r_in_valid;
    t_ptw_in         r_in;
    logic            r_out_valid;
    t_ptw_out        r_out;

    t_ptw_step       step;
    logic            out_ready;
    logic            proc;
    logic            in_take;
    logic            n_out_valid;

    ptw_step u_step (
        .i_level       (r_level),
        .i_saved_va    (r_saved_va),
        .i_saved_snap  (r_saved_snap),
        .i_paging_mode (r_paging_mode),
        .i_item        (r_in),
        .o_step        (step)
    );

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && (!step.res_valid || out_ready);
    assign o_in_stall = r_in_valid && !proc;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (proc && step.res_valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paging_mode <= 1'b0;
            r_level       <= LVL_IDLE;
            r_saved_va    <= '0;
            r_saved_snap  <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_paging_mode <= i_cfg_wdata;
            end
            if (proc) begin
                r_level <= step.level;
                if (step.latch_start) begin
                    r_saved_va   <= r_in.virt_addr[VA_W-1:0];
                    r_saved_snap <= r_in.use_snapshot;
                end
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (proc && step.res_valid) begin
            r_out <= step.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/ptw_step.sv */
// One walk step: next level and result for one transaction at the current
// level. Depends on ptw_pkg.
module ptw_step import ptw_pkg::*; (
    input  t_walk_level       i_level,
    input  logic [VA_W-1:0]   i_saved_va,
    input  logic              i_saved_snap,
    input  logic              i_paging_mode,
    input  t_ptw_in           i_item,
    output t_ptw_step         o_step
);

    logic [63:0]      entry;
    logic             present;
    logic             big_page;
    logic [VA_W-1:0]  new_va;
    t_walk_level      n_level;
    logic             n_latch_start;
    logic             step_valid;
    t_ptw_out         step_res;

    assign entry    = i_item.read_failed ? 64'd0 : i_item.entry_data;
    assign present  = entry[0];
    assign big_page = entry[7];
    assign new_va   = i_item.virt_addr[VA_W-1:0];

    function automatic t_ptw_out read_req(input logic [63:0] base,
                                          input logic [IDX_W-1:0] idx,
                                          input logic snap);
        t_ptw_out r;
        logic [63:0] sum;
        sum = base + 64'({idx, 3'b000});
        r = '0;
        r.kind = KIND_READ;
        r.read_addr = sum[RD_ADDR_W-1:0];
        r.rd_snap = snap;
        return r;
    endfunction

    function automatic t_ptw_out done(input logic [63:0] phys, input logic flt,
                                      input logic [1:0] pk);
        t_ptw_out r;
        r = '0;
        r.kind = KIND_DONE;
        r.xlat_addr = phys;
        r.fault = flt;
        r.page_kind = pk;
        return r;
    endfunction

    // next state
    always_comb begin
        n_level = i_level;
        n_latch_start = 1'b0;
        if (i_item.cmd == CMD_START) begin
            n_latch_start = i_paging_mode;
            n_level = i_paging_mode ? LVL_4 : LVL_IDLE;
        end else if (i_level != LVL_IDLE) begin
            if (!present) begin
                n_level = LVL_IDLE;
            end else begin
                unique case (i_level)
                    LVL_4: n_level = LVL_3;
                    LVL_3: n_level = big_page ? LVL_IDLE : LVL_2;
                    LVL_2: n_level = big_page ? LVL_IDLE : LVL_1;
                    default: n_level = LVL_IDLE;
                endcase
            end
        end
    end

    // outputs
    always_comb begin
        step_valid = 1'b1;
        step_res = '0;
        if (i_item.cmd == CMD_START) begin
            if (i_paging_mode) begin
                step_res = read_req(i_item.root_table & FRAME_4K_MASK,
                                    new_va[47:39], i_item.use_snapshot);
            end else begin
                step_res = done({32'd0, i_item.virt_addr[31:0]}, 1'b0, PAGE_UNPAGED);
            end
        end else if (i_level == LVL_IDLE) begin
            step_valid = 1'b0;
        end else if (!present) begin
            step_res = done(ALL_ONES, 1'b1, PAGE_4K);
        end else begin
            unique case (i_level)
                LVL_4: step_res = read_req(entry & FRAME_4K_MASK, i_saved_va[38:30],
                                           i_saved_snap);
                LVL_3: begin
                    if (big_page) begin
                        step_res = done((entry & FRAME_1G_MASK)
                                        | 64'(i_saved_va[29:0]), 1'b0, PAGE_1G);
                    end else begin
                        step_res = read_req(entry & FRAME_4K_MASK, i_saved_va[29:21],
                                            i_saved_snap);
                    end
                end
                LVL_2: begin
                    if (big_page) begin
                        step_res = done((entry & FRAME_2M_MASK)
                                        | 64'(i_saved_va[20:0]), 1'b0, PAGE_2M);
                    end else begin
                        step_res = read_req(entry & FRAME_4K_MASK, i_saved_va[20:12],
                                            i_saved_snap);
                    end
                end
                default: step_res = done((entry & FRAME_4K_MASK)
                                         | 64'(i_saved_va[11:0]), 1'b0, PAGE_4K);
            endcase
        end
    end

    assign o_step = '{res_valid: step_valid, latch_start: n_latch_start,
                      level: n_level, res: step_res};

endmodule

/* sim/four_level_page_table_walker_top_tb.sv */
// Testbench for four_level_page_table_walker_top: directed and random page walks
// are checked against an in-bench walk predictor. Depends on ptw_pkg and the RTL.
module four_level_page_table_walker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptw_pkg::*;

    class ptw_scoreboard;
        bit          paging = 1'b0;
        t_walk_level lvl = LVL_IDLE;
        logic [47:0] vaddr = '0;
        logic        snap = 1'b0;
        t_ptw_out    expq[$];
        int          errors = 0;

        function void set_paging(bit m);
            paging = m;
        endfunction

        function int pending();
            return expq.size();
        endfunction

        function t_ptw_out read_req(logic [63:0] ent, logic [8:0] idx);
            t_ptw_out r;
            logic [63:0] base;
            base = ent & FRAME_4K_MASK;
            r = '0;
            r.kind = KIND_READ;
            r.read_addr = RD_ADDR_W'(base + {52'b0, idx, 3'b0});
            r.rd_snap = snap;
            return r;
        endfunction

        function t_ptw_out walk_done(logic [63:0] phys, logic flt, logic [1:0] pk);
            t_ptw_out r;
            r = '0;
            r.kind = KIND_DONE;
            r.xlat_addr = phys;
            r.fault = flt;
            r.page_kind = pk;
            return r;
        endfunction

        // returns 1 when the transaction produces a result
        function int note_input(t_ptw_in x);
            logic [63:0] ent;
            if (x.cmd == CMD_START) begin
                if (!paging) begin
                    lvl = LVL_IDLE;
                    expq.push_back(walk_done({32'b0, x.virt_addr[31:0]}, 1'b0, PAGE_UNPAGED));
                    return 1;
                end
                vaddr = x.virt_addr[47:0];
                snap = x.use_snapshot;
                lvl = LVL_4;
                expq.push_back(read_req(x.root_table, vaddr[47:39]));
                return 1;
            end
            if (lvl == LVL_IDLE)
                return 0;
            ent = x.read_failed ? 64'b0 : x.entry_data;
            if (!ent[0]) begin
                lvl = LVL_IDLE;
                expq.push_back(walk_done(ALL_ONES, 1'b1, PAGE_4K));
                return 1;
            end
            case (lvl)
                LVL_4: begin
                    lvl = LVL_3;
                    expq.push_back(read_req(ent, vaddr[38:30]));
                end
                LVL_3: begin
                    if (ent[7]) begin
                        lvl = LVL_IDLE;
                        expq.push_back(walk_done((ent & FRAME_1G_MASK) | {34'b0, vaddr[29:0]},
                                                 1'b0, PAGE_1G));
                    end else begin
                        lvl = LVL_2;
                        expq.push_back(read_req(ent, vaddr[29:21]));
                    end
                end
                LVL_2: begin
                    if (ent[7]) begin
                        lvl = LVL_IDLE;
                        expq.push_back(walk_done((ent & FRAME_2M_MASK) | {43'b0, vaddr[20:0]},
                                                 1'b0, PAGE_2M));
                    end else begin
                        lvl = LVL_1;
                        expq.push_back(read_req(ent, vaddr[20:12]));
                    end
                end
                default: begin
                    lvl = LVL_IDLE;
                    expq.push_back(walk_done((ent & FRAME_4K_MASK) | {52'b0, vaddr[11:0]},
                                             1'b0, PAGE_4K));
                end
            endcase
            return 1;
        endfunction

        function void cmp(string fname, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_ptw_out got);
            t_ptw_out e;
            if (expq.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = expq.pop_front();
            cmp("kind", 64'(e.kind), 64'(got.kind));
            cmp("read_addr", 64'(e.read_addr), 64'(got.read_addr));
            cmp("rd_snap", 64'(e.rd_snap), 64'(got.rd_snap));
            cmp("xlat_addr", e.xlat_addr, got.xlat_addr);
            cmp("fault", 64'(e.fault), 64'(got.fault));
            cmp("page_kind", 64'(e.page_kind), 64'(got.page_kind));
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    logic     cfg_wdata = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_ptw_in  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_ptw_out out_data;

    ptw_scoreboard sb = new();
    bit idle_on = 1'b1;
    int n_res = 0;

    four_level_page_table_walker_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("** four_level_page_table_walker_top: FAILED **");
        $finish;
    end

    initial begin
        forever begin
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (idle_on) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_ptw_in mk_start(logic [63:0] root, logic [63:0] va, logic s);
        t_ptw_in x;
        x.cmd = CMD_START;
        x.root_table = root;
        x.virt_addr = va;
        x.use_snapshot = s;
        x.entry_data = rnd64();
        x.read_failed = 1'($urandom_range(0, 1));
        return x;
    endfunction

    function automatic t_ptw_in mk_entry(logic [63:0] data, logic failed);
        t_ptw_in x;
        x.cmd = CMD_ENTRY;
        x.root_table = rnd64();
        x.virt_addr = rnd64();
        x.use_snapshot = 1'($urandom_range(0, 1));
        x.entry_data = data;
        x.read_failed = failed;
        return x;
    endfunction

    function automatic t_ptw_in rand_item();
        t_ptw_in x;
        x = mk_entry(rnd64(), 1'($urandom_range(0, 1)));
        x.cmd = $urandom_range(0, 1) ? CMD_ENTRY : CMD_START;
        return x;
    endfunction

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send(t_ptw_in x);
        bit acc;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= x;
        do begin
            @(negedge clk);
            acc = !in_stall;
            @(posedge clk);
        end while (!acc);
        n_res += sb.note_input(x);
    endtask

    task automatic write_paging(bit m);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_paging(m);
    endtask

    task automatic random_walk();
        int r;
        logic [63:0] d;
        send(mk_start(rnd64(), rnd64(), 1'($urandom_range(0, 1))));
        for (int lv = 4; lv >= 1; lv--) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                return;
            if (r < 12) begin
                d = rnd64();
                if (r < 8) begin
                    d[0] = 1'b0;
                    send(mk_entry(d, 1'b0));
                end else begin
                    send(mk_entry(d, 1'b1));
                end
                return;
            end
            if (r < 15)
                send(mk_entry(rnd64(), 1'($urandom_range(0, 1))));
            d = rnd64();
            d[0] = 1'b1;
            if (lv == 3 || lv == 2)
                d[7] = (r < 40);
            send(mk_entry(d, 1'b0));
            if (d[7] && (lv == 3 || lv == 2))
                return;
        end
    endtask

    initial begin
        int phase_len;
        bit m;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unpaged after reset
        send(mk_start(rnd64(), ALL_ONES, 1'b1));
        send(mk_start(64'b0, 64'b0, 1'b0));
        send(mk_entry(ALL_ONES, 1'b0));

        write_paging(1'b1);
        // 1 GiB page, all-ones extremes
        send(mk_start(ALL_ONES, ALL_ONES, 1'b1));
        send(mk_entry(ALL_ONES, 1'b0));
        send(mk_entry(ALL_ONES, 1'b0));
        // 2 MiB page, zero address
        send(mk_start(64'b0, 64'b0, 1'b0));
        send(mk_entry(64'h1, 1'b0));
        send(mk_entry(64'h1, 1'b0));
        send(mk_entry(64'h81, 1'b0));
        // 4 KiB page with PAT bit set in the leaf
        send(mk_start(rnd64(), ALL_ONES, 1'b1));
        send(mk_entry(64'h1, 1'b0));
        send(mk_entry(64'h1, 1'b0));
        send(mk_entry(64'h1, 1'b0));
        send(mk_entry(ALL_ONES, 1'b0));
        // faults: not present, then failed read
        send(mk_start(rnd64(), rnd64(), 1'b0));
        send(mk_entry(ALL_ONES - 64'h1, 1'b0));
        send(mk_start(rnd64(), rnd64(), 1'b1));
        send(mk_entry(ALL_ONES, 1'b0));
        send(mk_entry(ALL_ONES, 1'b1));
        send(mk_entry(ALL_ONES, 1'b0));
        // restart while busy
        send(mk_start(rnd64(), rnd64(), 1'b1));
        send(mk_entry(64'h1, 1'b0));
        send(mk_start(rnd64(), rnd64(), 1'b0));
        send(mk_entry(64'h3, 1'b0));
        // mode cleared in the middle of a walk
        write_paging(1'b0);
        send(mk_entry(64'h1, 1'b0));
        send(mk_entry(64'h1, 1'b0));
        send(mk_entry(rnd64() | 64'h1, 1'b0));
        send(mk_start(rnd64(), rnd64(), 1'b1));

        while (n_res < 1650) begin
            m = ($urandom_range(0, 3) != 0);
            write_paging(m);
            phase_len = n_res + $urandom_range(150, 300);
            while (n_res < phase_len && n_res < 1650) begin
                if (n_res > 1350)
                    idle_on = 1'b0;
                if (m) begin
                    if ($urandom_range(0, 19) == 0)
                        send(rand_item());
                    else
                        random_walk();
                end else begin
                    if ($urandom_range(0, 6) == 0)
                        send(mk_entry(rnd64(), 1'($urandom_range(0, 1))));
                    else
                        send(mk_start(rnd64(), rnd64(), 1'($urandom_range(0, 1))));
                end
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("** four_level_page_table_walker_top: PASSED **");
        else
            $display("** four_level_page_table_walker_top: FAILED **");
        $finish;
    end

endmodule
